/* sv/vbd_pkg.sv */
`default_nettype none

package vbd_pkg;

    // Default sizes of the block.
    localparam int DEF_MAX_CHANNELS = 64;
    localparam int DEF_MAX_WINDOW   = 1024;
    localparam int DEF_SAMPLE_BITS  = 32;

    // Width of the window length register and of the channel index field.
    localparam int CFG_BITS = 11;
    localparam int IDX_BITS = 6;

    // Per-request control that travels with an element into the accumulator.
    typedef struct packed {
        logic take;         // element lies within the channel limit
        logic final_frame;  // element belongs to the last frame of a window
        logic clear_all;    // element ends the last frame of a window
        logic mean_last;    // result closes the output frame
    } acc_ctl_t;

    // Divider sequencer states.
    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_ABS,
        DIV_RUN,
        DIV_FIX,
        DIV_DONE
    } div_state_t;

endpackage

`default_nettype wire

/* sv/vector_boxcar_decimator_top.sv */
// Channel   Dir  Handshake                    Content
// s_axis    in   s_axis_tvalid/s_axis_tready  one frame element, tlast ends the frame
// m_axis    out  m_axis_tvalid/m_axis_tready  one channel mean, tlast ends the output frame
// cfg       in   cfg_valid/cfg_ready          window length, frames per output frame
//
// Elements of a non-final frame are taken one per cycle while the divider is idle; each
// costs one read and one write of the sum memory, with forwarding between them.
// An element of the final frame of a window holds intake until the bit-serial divider,
// which handles one mean at a time, has handed its mean on.
// Reset clears the counters and the sum valid bits at once; no clearing pass.
// A stalled result sits in the output register while intake goes on.
`default_nettype none

module vector_boxcar_decimator_top
    import vbd_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [CFG_BITS-1:0]                  cfg_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // sample_value in the low SAMPLE_BITS bits, zero padded to bytes
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // last_in_frame
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // mean_value in the low SAMPLE_BITS bits, zero padded to bytes
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]    m_axis_tdata,
    // channel_index
    output logic [IDX_BITS-1:0]                       m_axis_tuser,
    // mean_last
    output logic                                      m_axis_tlast
);

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CH_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);

    logic [CFG_BITS-1:0]      len_reg;
    logic [CH_BITS-1:0]       ch_reg;
    logic                     beyond_reg;
    logic [CFG_BITS-1:0]      pos_reg;

    logic                     in_accept;
    logic [CFG_BITS:0]        pos_inc;
    logic                     final_frame;
    logic                     last_ch;
    acc_ctl_t                 req_ctl;

    logic                     done_valid;
    logic signed [SUM_BITS-1:0] done_sum;
    logic [CH_BITS-1:0]       done_ch;
    logic                     done_last;

    logic                     div_busy;
    logic                     res_valid;
    logic                     res_ready;
    logic [SAMPLE_BITS-1:0]   res_value;
    logic [IDX_BITS-1:0]      res_idx;
    logic                     res_last;

    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   out_value_reg;
    logic [IDX_BITS-1:0]      out_idx_reg;
    logic                     out_last_reg;

    // Intake stalls while a final-frame element is on its way through the divider.
    assign s_axis_tready = !div_busy && !done_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Frame bookkeeping for the element at the input.
    always_comb
    begin
        pos_inc             = {1'b0, pos_reg} + 1'b1;
        final_frame         = pos_inc >= {1'b0, len_reg};
        last_ch             = ch_reg == CH_BITS'(MAX_CHANNELS - 1);
        req_ctl.take        = !beyond_reg;
        req_ctl.final_frame = final_frame;
        req_ctl.clear_all   = s_axis_tlast && final_frame;
        req_ctl.mean_last   = s_axis_tlast || last_ch;
    end

    // Effective window length, clamped when written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= CFG_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_data == '0)
            begin
                len_reg <= CFG_BITS'(1);
            end
            else if (32'(cfg_data) > MAX_WINDOW)
            begin
                len_reg <= CFG_BITS'(MAX_WINDOW);
            end
            else
            begin
                len_reg <= cfg_data;
            end
        end
    end

    // Channel counter and window position; the frame end takes priority.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg     <= '0;
            beyond_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else if (in_accept)
        begin
            if (s_axis_tlast)
            begin
                ch_reg     <= '0;
                beyond_reg <= 1'b0;
                pos_reg    <= final_frame ? '0 : pos_inc[CFG_BITS-1:0];
            end
            else if (!beyond_reg)
            begin
                if (last_ch)
                begin
                    beyond_reg <= 1'b1;
                end
                else
                begin
                    ch_reg <= ch_reg + 1'b1;
                end
            end
        end
    end

    vbd_accum #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_accept),
        .req_ctl    (req_ctl),
        .req_ch     (ch_reg),
        .req_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .done_valid (done_valid),
        .done_sum   (done_sum),
        .done_ch    (done_ch),
        .done_last  (done_last)
    );

    vbd_divider #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (done_valid),
        .start_sum  (done_sum),
        .start_len  (len_reg),
        .start_idx  (IDX_BITS'(done_ch)),
        .start_last (done_last),
        .busy       (div_busy),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_value  (res_value),
        .res_idx    (res_idx),
        .res_last   (res_last)
    );

    // Output register between the divider and the result channel.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_value_reg <= res_value;
            out_idx_reg   <= res_idx;
            out_last_reg  <= res_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_BITS'(out_value_reg);
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* sv/vbd_accum.sv */
`default_nettype none

module vbd_accum
    import vbd_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           req_valid,
    input  wire acc_ctl_t                                       req_ctl,
    input  wire logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] req_ch,
    input  wire logic signed [SAMPLE_BITS-1:0]                  req_sample,
    output logic                                                done_valid,
    output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]    done_sum,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] done_ch,
    output logic                                                done_last
);

    localparam int CH_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

    // Channel sum storage, one read port and one write port.
    logic signed [SUM_BITS-1:0] sum_mem [MAX_CHANNELS];
    logic signed [SUM_BITS-1:0] rd_data_reg;

    // One bit per entry: a cleared bit makes the entry read as zero.
    logic [MAX_CHANNELS-1:0] live_reg;

    // Read-modify-write stage.
    logic                        s1_valid_reg;
    acc_ctl_t                    s1_ctl_reg;
    logic [CH_BITS-1:0]          s1_ch_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;

    // Last value written, for an entry read in the same cycle it was written.
    logic                        fwd_valid_reg;
    logic [CH_BITS-1:0]          fwd_ch_reg;
    logic signed [SUM_BITS-1:0]  fwd_data_reg;

    logic signed [SUM_BITS-1:0]  sample_ext;
    logic signed [SUM_BITS-1:0]  base;
    logic signed [SUM_BITS-1:0]  sum_new;
    logic signed [SUM_BITS-1:0]  store_val;
    logic                        wr_en;

    // Select the current sum and add the new element.
    always_comb
    begin
        sample_ext = SUM_BITS'(s1_sample_reg);
        if (fwd_valid_reg && (fwd_ch_reg == s1_ch_reg))
        begin
            base = fwd_data_reg;
        end
        else if (live_reg[s1_ch_reg])
        begin
            base = rd_data_reg;
        end
        else
        begin
            base = '0;
        end
        sum_new   = base + sample_ext;
        wr_en     = s1_valid_reg && s1_ctl_reg.take && !s1_ctl_reg.final_frame;
        store_val = s1_ctl_reg.final_frame ? '0 : sum_new;
    end

    // A final-frame element hands its sum to the divider.
    assign done_valid = s1_valid_reg && s1_ctl_reg.take && s1_ctl_reg.final_frame;
    assign done_sum   = sum_new;
    assign done_ch    = s1_ch_reg;
    assign done_last  = s1_ctl_reg.mean_last;

    // Sum memory: read at request time, written back in the following cycle.
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            rd_data_reg <= sum_mem[req_ch];
        end
        if (wr_en)
        begin
            sum_mem[s1_ch_reg] <= sum_new;
        end
    end

    // Entry valid bits: set as an entry is written, cleared as its mean is taken, all cleared at the end of a window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_ctl_reg.clear_all)
            begin
                live_reg <= '0;
            end
            else if (s1_ctl_reg.take)
            begin
                live_reg[s1_ch_reg] <= !s1_ctl_reg.final_frame;
            end
        end
    end

    // Stage and forwarding control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= req_valid;
            fwd_valid_reg <= s1_valid_reg && s1_ctl_reg.take;
        end
    end

    // Stage and forwarding payload.
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            s1_ctl_reg    <= req_ctl;
            s1_ch_reg     <= req_ch;
            s1_sample_reg <= req_sample;
        end
        fwd_ch_reg   <= s1_ch_reg;
        fwd_data_reg <= store_val;
    end

endmodule

`default_nettype wire

/* sv/vbd_divider.sv */
`default_nettype none

module vbd_divider
    import vbd_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        start,
    input  wire logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0] start_sum,
    input  wire logic [CFG_BITS-1:0]                         start_len,
    input  wire logic [IDX_BITS-1:0]                         start_idx,
    input  wire logic                                        start_last,
    output logic                                             busy,
    output logic                                             res_valid,
    input  wire logic                                        res_ready,
    output logic [SAMPLE_BITS-1:0]                           res_value,
    output logic [IDX_BITS-1:0]                              res_idx,
    output logic                                             res_last
);

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    localparam logic [SUM_BITS-1:0] POS_MAX =
        SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [SUM_BITS-1:0] NEG_MAG = SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] HI_VAL = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] LO_VAL = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    div_state_t state_reg;
    div_state_t state_next;

    logic                    neg_reg;
    logic [SUM_BITS-1:0]     num_reg;
    logic [CFG_BITS-1:0]     rem_reg;
    logic [CFG_BITS-1:0]     len_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [IDX_BITS-1:0]     idx_reg;
    logic                    last_reg;
    logic [SAMPLE_BITS-1:0]  value_reg;

    logic [SUM_BITS-1:0]     num_neg;
    logic [CFG_BITS:0]       rem_shift;
    logic [CFG_BITS+1:0]     diff;
    logic                    fits;
    logic [SAMPLE_BITS-1:0]  sat_value;

    // One restoring step per cycle, plus negate and saturate.
    always_comb
    begin
        num_neg   = -num_reg;
        rem_shift = {rem_reg, num_reg[SUM_BITS-1]};
        diff      = {1'b0, rem_shift} - {2'b00, len_reg};
        fits      = !diff[CFG_BITS+1];
        if (neg_reg)
        begin
            sat_value = (num_reg > NEG_MAG) ? LO_VAL : num_neg[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat_value = (num_reg > POS_MAX) ? HI_VAL : num_reg[SAMPLE_BITS-1:0];
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        res_valid  = 1'b0;
        case (state_reg)
            DIV_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = DIV_ABS;
                end
            end
            DIV_ABS:
            begin
                state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                if (cnt_reg == CNT_BITS'(SUM_BITS - 1))
                begin
                    state_next = DIV_FIX;
                end
            end
            DIV_FIX:
            begin
                state_next = DIV_DONE;
            end
            DIV_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    // Datapath: load, take magnitude, shift-subtract, saturate.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    num_reg  <= start_sum;
                    neg_reg  <= start_sum[SUM_BITS-1];
                    len_reg  <= start_len;
                    idx_reg  <= start_idx;
                    last_reg <= start_last;
                end
            end
            DIV_ABS:
            begin
                num_reg <= neg_reg ? num_neg : num_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            DIV_RUN:
            begin
                rem_reg <= fits ? diff[CFG_BITS-1:0] : rem_shift[CFG_BITS-1:0];
                num_reg <= {num_reg[SUM_BITS-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
            end
            DIV_FIX:
            begin
                value_reg <= sat_value;
            end
            default:
            begin
            end
        endcase
    end

    assign res_value = value_reg;
    assign res_idx   = idx_reg;
    assign res_last  = last_reg;

endmodule

`default_nettype wire

/* sv/vbd_checker.sv */
`default_nettype none

module vbd_checker
    import vbd_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   s_axis_tvalid,
    input wire logic                                   s_axis_tready,
    input wire logic                                   m_axis_tvalid,
    input wire logic                                   m_axis_tready,
    input wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    input wire logic [IDX_BITS-1:0]                    m_axis_tuser,
    input wire logic                                   m_axis_tlast
);

    // A stalled result keeps its content.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A result leaves only after the consumer took it.
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result withdrawn without a request taken");

    // A new result only shows up while intake is held for the division.
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while intake was open");

    // Intake only closes after an element was taken.
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
        else $error("intake closed without a request");

endmodule

bind vector_boxcar_decimator_top vbd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_vbd_checker (.*);

`default_nettype wire
